// ----- src/sit_pkg.sv -----
// Shared types and constants for the segment intersection block.
package sit_pkg;

  localparam int unsigned OUT_W        = 22;
  localparam int unsigned MARGIN_W     = 8;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd10;

  // Sideband carried alongside each divider request
  typedef struct packed {
    logic found;
    logic neg_x;
    logic neg_y;
  } sit_ctl_t;

endpackage

// ----- src/sit_front.sv -----
// Front arithmetic: determinant, numerators, box tests and dividend set-up over six stages.
module sit_front import sit_pkg::*; #(
  parameter int unsigned CW  = 12,
  parameter int unsigned FW  = 8,
  parameter int unsigned DW  = 2 * CW + 3,
  parameter int unsigned NUW = 3 * CW + 3 + FW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [5:0]          en_i,
  input  logic                valid_i,
  input  logic [CW-1:0]       x1_i,
  input  logic [CW-1:0]       y1_i,
  input  logic [CW-1:0]       x2_i,
  input  logic [CW-1:0]       y2_i,
  input  logic [CW-1:0]       x3_i,
  input  logic [CW-1:0]       y3_i,
  input  logic [CW-1:0]       x4_i,
  input  logic [CW-1:0]       y4_i,
  input  logic [MARGIN_W-1:0] margin_i,
  output logic [5:0]          v_o,
  output sit_ctl_t            ctl_o,
  output logic [DW-1:0]       den_o,
  output logic [NUW-1:0]      num_x_o,
  output logic [NUW-1:0]      num_y_o
);

  localparam int unsigned DFW  = CW + 1;
  localparam int unsigned PW   = 2 * CW;
  localparam int unsigned CCW  = PW + 1;
  localparam int unsigned MW   = CCW + DFW;
  localparam int unsigned NW   = MW + 1;
  localparam int unsigned BW   = ((CW > 8) ? CW : 8) + 2;
  localparam int unsigned CMPW = BW + DW + 1;

  logic [5:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en_i[0]) v_q[0] <= valid_i;
      for (int k = 1; k < 6; k++) begin
        if (en_i[k]) v_q[k] <= v_q[k-1];
      end
    end
  end
  assign v_o = v_q;

  // stage 1: differences, single products, bounds
  logic signed [DFW-1:0] dx12_q, dy12_q, dx34_q, dy34_q;
  logic signed [2*DFW-1:0] pd1_q, pd2_q;
  logic [PW-1:0] pa_q, pb_q, pc_q, pe_q;
  logic signed [BW-1:0] b1_q [8];

  logic signed [DFW-1:0] dx12_d, dy12_d, dx34_d, dy34_d;
  logic signed [BW-1:0]  b1_d [8];

  function automatic logic signed [BW-1:0] lo_b(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                               input logic [MARGIN_W-1:0] m);
    logic [CW-1:0] mn;
    mn = (a < b) ? a : b;
    return $signed(BW'(mn)) - $signed(BW'(m));
  endfunction

  function automatic logic signed [BW-1:0] hi_b(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                               input logic [MARGIN_W-1:0] m);
    logic [CW-1:0] mx;
    mx = (a > b) ? a : b;
    return $signed(BW'(mx)) + $signed(BW'(m));
  endfunction

  always_comb begin
    dx12_d  = $signed({1'b0, x1_i}) - $signed({1'b0, x2_i});
    dy12_d  = $signed({1'b0, y1_i}) - $signed({1'b0, y2_i});
    dx34_d  = $signed({1'b0, x3_i}) - $signed({1'b0, x4_i});
    dy34_d  = $signed({1'b0, y3_i}) - $signed({1'b0, y4_i});
    b1_d[0] = lo_b(x1_i, x2_i, margin_i);
    b1_d[1] = hi_b(x1_i, x2_i, margin_i);
    b1_d[2] = lo_b(y1_i, y2_i, margin_i);
    b1_d[3] = hi_b(y1_i, y2_i, margin_i);
    b1_d[4] = lo_b(x3_i, x4_i, margin_i);
    b1_d[5] = hi_b(x3_i, x4_i, margin_i);
    b1_d[6] = lo_b(y3_i, y4_i, margin_i);
    b1_d[7] = hi_b(y3_i, y4_i, margin_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dx12_q <= dx12_d;
      dy12_q <= dy12_d;
      dx34_q <= dx34_d;
      dy34_q <= dy34_d;
      pd1_q  <= dx12_d * dy34_d;
      pd2_q  <= dy12_d * dx34_d;
      pa_q   <= x1_i * y2_i;
      pb_q   <= y1_i * x2_i;
      pc_q   <= x3_i * y4_i;
      pe_q   <= y3_i * x4_i;
      b1_q   <= b1_d;
    end
  end

  // stage 2: determinant and cross terms
  logic signed [DW-1:0]  d2_q;
  logic signed [CCW-1:0] c1_q, c2_q;
  logic signed [DFW-1:0] dx12_2_q, dy12_2_q, dx34_2_q, dy34_2_q;
  logic signed [BW-1:0]  b2_q [8];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      d2_q     <= DW'(pd1_q) - DW'(pd2_q);
      c1_q     <= $signed({1'b0, pa_q}) - $signed({1'b0, pb_q});
      c2_q     <= $signed({1'b0, pc_q}) - $signed({1'b0, pe_q});
      dx12_2_q <= dx12_q;
      dy12_2_q <= dy12_q;
      dx34_2_q <= dx34_q;
      dy34_2_q <= dy34_q;
      b2_q     <= b1_q;
    end
  end

  // stage 3: numerator products
  logic signed [MW-1:0] m1_q, m2_q, m3_q, m4_q;
  logic signed [DW-1:0] d3_q;
  logic signed [BW-1:0] b3_q [8];

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      m1_q <= MW'(c1_q) * MW'(dx34_2_q);
      m2_q <= MW'(dx12_2_q) * MW'(c2_q);
      m3_q <= MW'(c1_q) * MW'(dy34_2_q);
      m4_q <= MW'(dy12_2_q) * MW'(c2_q);
      d3_q <= d2_q;
      b3_q <= b2_q;
    end
  end

  // stage 4: numerators, sign normalised to a positive denominator
  logic signed [NW-1:0] nx4_q, ny4_q, nx4_d, ny4_d;
  logic [DW-1:0]        dn4_q;
  logic                 dnz4_q;
  logic signed [BW-1:0] b4_q [8];

  always_comb begin
    nx4_d = NW'(m1_q) - NW'(m2_q);
    ny4_d = NW'(m3_q) - NW'(m4_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      nx4_q  <= d3_q[DW-1] ? -nx4_d : nx4_d;
      ny4_q  <= d3_q[DW-1] ? -ny4_d : ny4_d;
      dn4_q  <= d3_q[DW-1] ? DW'(-d3_q) : DW'(d3_q);
      dnz4_q <= (d3_q != '0);
      b4_q   <= b3_q;
    end
  end

  // stage 5: scaled box bounds
  logic signed [CMPW-1:0] bp5_q [8];
  logic signed [NW-1:0]   nx5_q, ny5_q;
  logic [DW-1:0]          dn5_q;
  logic                   dnz5_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      for (int k = 0; k < 8; k++) begin
        bp5_q[k] <= CMPW'(b4_q[k]) * $signed({1'b0, dn4_q});
      end
      nx5_q  <= nx4_q;
      ny5_q  <= ny4_q;
      dn5_q  <= dn4_q;
      dnz5_q <= dnz4_q;
    end
  end

  // stage 6: box tests and dividend magnitudes
  logic signed [CMPW-1:0] nxe, nye;
  logic [NW-1:0]          magx, magy;
  logic                   ok6;
  sit_ctl_t               ctl_q;
  logic [DW-1:0]          dn6_q;
  logic [NUW-1:0]         numx_q, numy_q;

  always_comb begin
    nxe  = CMPW'(nx5_q);
    nye  = CMPW'(ny5_q);
    ok6  = dnz5_q
        && (nxe >= bp5_q[0]) && (nxe <= bp5_q[1])
        && (nye >= bp5_q[2]) && (nye <= bp5_q[3])
        && (nxe >= bp5_q[4]) && (nxe <= bp5_q[5])
        && (nye >= bp5_q[6]) && (nye <= bp5_q[7]);
    magx = nx5_q[NW-1] ? NW'(-nx5_q) : NW'(nx5_q);
    magy = ny5_q[NW-1] ? NW'(-ny5_q) : NW'(ny5_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      ctl_q.found <= ok6;
      ctl_q.neg_x <= nx5_q[NW-1];
      ctl_q.neg_y <= ny5_q[NW-1];
      dn6_q       <= dn5_q;
      numx_q      <= NUW'(magx) << FW;
      numy_q      <= NUW'(magy) << FW;
    end
  end

  assign ctl_o   = ctl_q;
  assign den_o   = dn6_q;
  assign num_x_o = numx_q;
  assign num_y_o = numy_q;

endmodule

// ----- src/sit_div_step.sv -----
// One restoring division step for both axes, one quotient bit per stage.
module sit_div_step import sit_pkg::*; #(
  parameter int unsigned RW    = 64,
  parameter int unsigned DW    = 27,
  parameter int unsigned QB    = 21,
  parameter int unsigned SHIFT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  sit_ctl_t      ctl_i,
  input  logic [DW-1:0] den_i,
  input  logic [RW-1:0] rem_x_i,
  input  logic [RW-1:0] rem_y_i,
  input  logic [QB-1:0] q_x_i,
  input  logic [QB-1:0] q_y_i,
  output logic          valid_o,
  output sit_ctl_t      ctl_o,
  output logic [DW-1:0] den_o,
  output logic [RW-1:0] rem_x_o,
  output logic [RW-1:0] rem_y_o,
  output logic [QB-1:0] q_x_o,
  output logic [QB-1:0] q_y_o
);

  logic [RW-1:0] trial;
  logic          gex, gey;

  always_comb begin
    trial = RW'(den_i) << SHIFT;
    gex   = (rem_x_i >= trial);
    gey   = (rem_y_i >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o   <= ctl_i;
      den_o   <= den_i;
      rem_x_o <= gex ? rem_x_i - trial : rem_x_i;
      rem_y_o <= gey ? rem_y_i - trial : rem_y_i;
      q_x_o   <= q_x_i | (QB'(gex) << SHIFT);
      q_y_o   <= q_y_i | (QB'(gey) << SHIFT);
    end
  end

endmodule

// ----- src/segment_intersection_tolerance.sv -----
// Top level: line crossing of two pixel segments with bounding-box tolerance.
//
//  channel   | dir | handshake                   | contents (lowest bits first)
//  ----------+-----+-----------------------------+----------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready | tdata: x1, y1, x2, y2, x3, y3, x4, y4
//  m_axis    | out | m_axis_tvalid/m_axis_tready | tdata: cross_x_q8, cross_y_q8; tuser: found
//  cfg       | in  | cfg_valid_i/cfg_ready_o     | cfg_data_i: margin in pixels
//
// One request per clock sustained while m_axis_tready keeps the output moving. The
// restoring divider resolves QB = max(COORD_BITS,8) + 1 + FRAC_BITS quotient bits (21 at
// the defaults), one quotient bit per stage.
// Reset clears all valid bits and loads the margin with 10; payload is not reset.
// A stall ripples back stage by stage: an empty stage keeps loading, so bubbles
// are squeezed out and the input stays ready while the pipeline has room.
module segment_intersection_tolerance import sit_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [8*COORD_BITS-1:0] s_axis_tdata,   // x1, y1, x2, y2, x3, y3, x4, y4
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [47:0]             m_axis_tdata,   // cross_x_q8 [21:0], cross_y_q8 [43:22], zero fill
  output logic                    m_axis_tuser,   // found
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [MARGIN_W-1:0]     cfg_data_i      // margin
);

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned DW  = 2 * CW + 3;
  localparam int unsigned NW  = 3 * CW + 3;
  localparam int unsigned NUW = NW + FRAC_BITS;
  localparam int unsigned QB  = ((CW > 8) ? CW : 8) + 1 + FRAC_BITS;
  localparam int unsigned RW  = (NUW > DW + QB) ? NUW : DW + QB;
  localparam int unsigned SW  = QB + OUT_W + 1;

  // margin register
  logic [MARGIN_W-1:0] margin_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MARGIN_RESET;
    end else if (cfg_valid_i) begin
      margin_q <= cfg_data_i;
    end
  end

  // stage enables, rippled back from the output register
  logic [5:0]    fv;
  logic [5:0]    fen;
  logic [QB-1:0] dv;
  logic [QB-1:0] den_en;
  logic          out_en;

  always_comb begin
    out_en = !m_axis_tvalid || m_axis_tready;
    den_en[QB-1] = !dv[QB-1] || out_en;
    for (int k = QB - 2; k >= 0; k--) begin
      den_en[k] = !dv[k] || den_en[k+1];
    end
    fen[5] = !fv[5] || den_en[0];
    for (int k = 4; k >= 0; k--) begin
      fen[k] = !fv[k] || fen[k+1];
    end
  end

  assign s_axis_tready = fen[0];

  // front arithmetic
  sit_ctl_t       f_ctl;
  logic [DW-1:0]  f_den;
  logic [NUW-1:0] f_nx, f_ny;

  sit_front #(.CW(CW), .FW(FRAC_BITS), .DW(DW), .NUW(NUW)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (fen),
    .valid_i  (s_axis_tvalid),
    .x1_i     (s_axis_tdata[0*CW +: CW]),
    .y1_i     (s_axis_tdata[1*CW +: CW]),
    .x2_i     (s_axis_tdata[2*CW +: CW]),
    .y2_i     (s_axis_tdata[3*CW +: CW]),
    .x3_i     (s_axis_tdata[4*CW +: CW]),
    .y3_i     (s_axis_tdata[5*CW +: CW]),
    .x4_i     (s_axis_tdata[6*CW +: CW]),
    .y4_i     (s_axis_tdata[7*CW +: CW]),
    .margin_i (margin_q),
    .v_o      (fv),
    .ctl_o    (f_ctl),
    .den_o    (f_den),
    .num_x_o  (f_nx),
    .num_y_o  (f_ny)
  );

  // divider chain, most significant quotient bit first
  logic          cv  [QB+1];
  sit_ctl_t      cc  [QB+1];
  logic [DW-1:0] cd  [QB+1];
  logic [RW-1:0] crx [QB+1];
  logic [RW-1:0] cry [QB+1];
  logic [QB-1:0] cqx [QB+1];
  logic [QB-1:0] cqy [QB+1];

  assign cv[0]  = fv[5];
  assign cc[0]  = f_ctl;
  assign cd[0]  = f_den;
  assign crx[0] = RW'(f_nx);
  assign cry[0] = RW'(f_ny);
  assign cqx[0] = '0;
  assign cqy[0] = '0;

  for (genvar g = 0; g < QB; g++) begin : g_div
    sit_div_step #(.RW(RW), .DW(DW), .QB(QB), .SHIFT(QB - 1 - g)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (den_en[g]),
      .valid_i (cv[g]),
      .ctl_i   (cc[g]),
      .den_i   (cd[g]),
      .rem_x_i (crx[g]),
      .rem_y_i (cry[g]),
      .q_x_i   (cqx[g]),
      .q_y_i   (cqy[g]),
      .valid_o (cv[g+1]),
      .ctl_o   (cc[g+1]),
      .den_o   (cd[g+1]),
      .rem_x_o (crx[g+1]),
      .rem_y_o (cry[g+1]),
      .q_x_o   (cqx[g+1]),
      .q_y_o   (cqy[g+1])
    );
    assign dv[g] = cv[g+1];
  end

  // output register: restore sign, zero a miss
  logic [SW-1:0]    sx, sy;
  logic [OUT_W-1:0] ox_d, oy_d, ox_q, oy_q;
  logic             found_q;
  sit_ctl_t         lc;

  always_comb begin
    lc   = cc[QB];
    sx   = lc.neg_x ? SW'(0) - SW'(cqx[QB]) : SW'(cqx[QB]);
    sy   = lc.neg_y ? SW'(0) - SW'(cqy[QB]) : SW'(cqy[QB]);
    ox_d = lc.found ? sx[OUT_W-1:0] : '0;
    oy_d = lc.found ? sy[OUT_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_en) begin
      m_axis_tvalid <= cv[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      found_q <= lc.found;
    end
  end

  assign m_axis_tdata = {(48 - 2 * OUT_W)'(0), oy_q, ox_q};
  assign m_axis_tuser = found_q;

  // checks
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss carries nonzero point");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fv[0] |-> s_axis_tready)
    else $error("empty first stage refused input");

  a_last_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && cv[QB] |=> cv[QB] && $stable(cqx[QB]))
    else $error("divider tail moved under stall");

endmodule
